/* src/lzss_pkg.sv */
// ============================================================================
// lzss_pkg: shared types and constants
// parser states, field widths and fixed token constants of the decompressor
// ============================================================================
package lzss_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 24;
    localparam int FLAG_W = 9;
    localparam int RUN_W  = 5;
    localparam int DIST_W = 12;

    // flag register holding only the sentinel bit: next byte is a flag
    localparam logic [FLAG_W-1:0] FLAG_EMPTY = 9'd1;
    // copy length is the low nibble plus this bias
    localparam logic [RUN_W-1:0]  RUN_BIAS   = 5'd2;
    localparam logic [RUN_W-1:0]  RUN_ONE    = 5'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_FLAG,
        ST_TOKEN,
        ST_HIGH,
        ST_COPY
    } t_state;

endpackage

/* src/lzss_decompressor_unit.sv */
// ============================================================================
// lzss_decompressor_unit: lzss decompressor with a sliding byte history
// parses flag bytes, literals and 16-bit back references, emits one byte
// per output transfer
// ============================================================================
// a back reference (len = 2..17) holds the input stalled while it is copied
//   out, one registered history read per output byte; output stalls hold the copy
// a literal appears on the output in the cycle after its input transfer
// reset: synchronous, active low; afterwards the history is swept to zero
//   with input stalled; config writes are taken
module lzss_decompressor_unit #(
    parameter int HISTORY_DEPTH = 4096,
    parameter int COUNT_BITS    = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_wr_en,
    input  logic [lzss_pkg::LEN_W-1:0]  i_cfg_wr_data,
    // compressed input
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [lzss_pkg::BYTE_W-1:0] i_in_byte,
    // decompressed output
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [lzss_pkg::BYTE_W-1:0] o_out_byte,
    output logic                        o_run_last,
    output logic                        o_stream_done
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);

    // history pointer step with wrap at the depth
    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == LAST_ADDR) ? '0 : p + 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    lzss_pkg::t_state                     r_state, n_state;
    logic [lzss_pkg::FLAG_W-1:0]          r_flag, n_flag;
    logic [lzss_pkg::BYTE_W-1:0]          r_low, n_low;
    logic [AW-1:0]                        r_wp, n_wp;
    logic [AW-1:0]                        r_src, n_src;
    logic [lzss_pkg::RUN_W-1:0]           r_len, n_len;
    logic [COUNT_BITS-1:0]                r_count, n_count;
    logic [lzss_pkg::LEN_W-1:0]           r_out_len;

    // output holding register
    logic                                 r_out_valid;
    logic [lzss_pkg::BYTE_W-1:0]          r_out_byte;
    logic                                 r_out_last;
    logic                                 r_out_done;

    // ------------------------------------------------------------------
    // combinational
    // ------------------------------------------------------------------
    logic                                 w_out_ok;
    logic                                 w_parse;
    logic                                 w_in_accept;
    logic [COUNT_BITS-1:0]                w_limit;
    logic [COUNT_BITS-1:0]                w_count_inc;
    logic                                 w_finished;
    logic                                 w_hit_end;
    logic [lzss_pkg::FLAG_W-1:0]          w_flag_shr;
    logic [lzss_pkg::DIST_W-1:0]          w_dist;
    logic [AW:0]                          w_src_sum;
    logic [AW-1:0]                        w_src0;

    logic                                 w_emit;
    logic [lzss_pkg::BYTE_W-1:0]          w_emit_byte;
    logic                                 w_emit_last;

    logic                                 w_hist_we;
    logic                                 w_hist_re;
    logic [AW-1:0]                        w_hist_raddr;
    logic [lzss_pkg::BYTE_W-1:0]          w_hist_rdata;
    logic                                 w_hist_busy;

    // output slot free this cycle, either empty or being drained
    assign w_out_ok    = !r_out_valid || !i_out_stall;
    assign w_parse     = (r_state == lzss_pkg::ST_FLAG) ||
                         (r_state == lzss_pkg::ST_TOKEN) ||
                         (r_state == lzss_pkg::ST_HIGH);
    assign o_in_stall  = !(w_parse && w_out_ok);
    assign w_in_accept = i_in_valid && !o_in_stall;

    // limit is the length register fitted to the counter width
    assign w_limit     = COUNT_BITS'(r_out_len);
    assign w_count_inc = r_count + 1'b1;
    assign w_finished  = r_count >= w_limit;
    assign w_hit_end   = w_count_inc >= w_limit;
    assign w_flag_shr  = {1'b0, r_flag[lzss_pkg::FLAG_W-1:1]};

    // copy source: write pointer minus distance, wrapped once
    assign w_dist    = {i_in_byte, r_low[7:4]};
    assign w_src_sum = {1'b0, r_wp} + DEPTH_EXT - (AW + 1)'(w_dist);
    assign w_src0    = (w_src_sum >= DEPTH_EXT) ? AW'(w_src_sum - DEPTH_EXT)
                                                : AW'(w_src_sum);

    always_comb begin
        n_state      = r_state;
        n_flag       = r_flag;
        n_low        = r_low;
        n_wp         = r_wp;
        n_src        = r_src;
        n_len        = r_len;
        n_count      = r_count;
        w_emit       = 1'b0;
        w_emit_byte  = i_in_byte;
        w_emit_last  = 1'b0;
        w_hist_we    = 1'b0;
        w_hist_re    = 1'b0;
        w_hist_raddr = r_src;

        case (r_state)
            lzss_pkg::ST_CLEAR: begin
                if (!w_hist_busy) begin
                    n_state = lzss_pkg::ST_FLAG;
                end
            end
            lzss_pkg::ST_FLAG: begin
                if (w_in_accept && !w_finished) begin
                    n_flag  = {1'b1, i_in_byte};
                    n_state = lzss_pkg::ST_TOKEN;
                end
            end
            lzss_pkg::ST_TOKEN: begin
                if (w_in_accept && !w_finished) begin
                    if (r_flag[0]) begin
                        // literal: straight to output and history
                        w_emit      = 1'b1;
                        w_emit_last = 1'b1;
                        w_hist_we   = 1'b1;
                        n_wp        = ptr_inc(r_wp);
                        n_count     = w_count_inc;
                        if (w_hit_end) begin
                            n_flag  = lzss_pkg::FLAG_EMPTY;
                            n_state = lzss_pkg::ST_FLAG;
                        end else begin
                            n_flag  = w_flag_shr;
                            n_state = (w_flag_shr == lzss_pkg::FLAG_EMPTY) ?
                                      lzss_pkg::ST_FLAG : lzss_pkg::ST_TOKEN;
                        end
                    end else begin
                        n_low   = i_in_byte;
                        n_state = lzss_pkg::ST_HIGH;
                    end
                end
            end
            lzss_pkg::ST_HIGH: begin
                if (w_in_accept && !w_finished) begin
                    // issue the first history read right away
                    w_hist_re    = 1'b1;
                    w_hist_raddr = w_src0;
                    n_src        = ptr_inc(w_src0);
                    n_len        = lzss_pkg::RUN_W'(r_low[3:0]) + lzss_pkg::RUN_BIAS;
                    n_flag       = w_flag_shr;
                    n_state      = lzss_pkg::ST_COPY;
                end
            end
            lzss_pkg::ST_COPY: begin
                // one byte per cycle while the output is free; the next read overlaps this write
                if (w_out_ok) begin
                    w_emit      = 1'b1;
                    w_emit_byte = w_hist_rdata;
                    w_emit_last = w_hit_end || (r_len == lzss_pkg::RUN_ONE);
                    w_hist_we   = 1'b1;
                    n_wp        = ptr_inc(r_wp);
                    n_count     = w_count_inc;
                    n_len       = r_len - 1'b1;
                    if (w_hit_end) begin
                        n_flag  = lzss_pkg::FLAG_EMPTY;
                        n_state = lzss_pkg::ST_FLAG;
                    end else if (r_len == lzss_pkg::RUN_ONE) begin
                        n_state = (r_flag == lzss_pkg::FLAG_EMPTY) ?
                                  lzss_pkg::ST_FLAG : lzss_pkg::ST_TOKEN;
                    end else begin
                        w_hist_re = 1'b1;
                        n_src     = ptr_inc(r_src);
                    end
                end
            end
            default: begin
                n_state = lzss_pkg::ST_CLEAR;
            end
        endcase

        // length write starts a new stream; history and pointer stay
        if (i_cfg_wr_en) begin
            n_count = '0;
            n_flag  = lzss_pkg::FLAG_EMPTY;
            n_low   = '0;
            if (r_state != lzss_pkg::ST_CLEAR) begin
                n_state = lzss_pkg::ST_FLAG;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lzss_pkg::ST_CLEAR;
            r_flag    <= lzss_pkg::FLAG_EMPTY;
            r_low     <= '0;
            r_wp      <= '0;
            r_count   <= '0;
            r_out_len <= '0;
        end else begin
            r_state <= n_state;
            r_flag  <= n_flag;
            r_low   <= n_low;
            r_wp    <= n_wp;
            r_count <= n_count;
            if (i_cfg_wr_en) begin
                r_out_len <= i_cfg_wr_data;
            end
        end
    end

    // copy bookkeeping, meaningful only inside a copy
    always_ff @(posedge i_clk) begin
        r_src <= n_src;
        r_len <= n_len;
    end

    // output register: loaded on emit, cleared once the transfer is done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_byte <= w_emit_byte;
            r_out_last <= w_emit_last;
            r_out_done <= w_hit_end;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_run_last    = r_out_last;
    assign o_stream_done = r_out_done;

    // ------------------------------------------------------------------
    // history memory
    // ------------------------------------------------------------------
    lzss_hist #(
        .DEPTH (HISTORY_DEPTH),
        .AW    (AW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_hist_we),
        .i_waddr (r_wp),
        .i_wdata (w_emit_byte),
        .i_re    (w_hist_re),
        .i_raddr (w_hist_raddr),
        .o_rdata (w_hist_rdata),
        .o_busy  (w_hist_busy)
    );

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // no parser write may collide with the zero fill sweep
    a_no_write_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hist_busy |-> !w_hist_we)
        else $error("history write during fill sweep");

    // a waiting output byte is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !w_emit)
        else $error("output register overwritten while stalled");

    // produced count never passes the configured length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= w_limit)
        else $error("produced count beyond limit");

    // a copy in progress always has bytes left
    a_copy_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lzss_pkg::ST_COPY) |-> (r_len != '0))
        else $error("copy with zero remaining length");

endmodule

/* src/lzss_hist.sv */
// ============================================================================
// lzss_hist: history memory
// single-port-write, registered-read byte store with write-to-read forwarding
// and a zero fill sweep after reset
// ============================================================================
module lzss_hist #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [lzss_pkg::BYTE_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [lzss_pkg::BYTE_W-1:0] o_rdata,
    output logic                       o_busy
);

    logic [lzss_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [lzss_pkg::BYTE_W-1:0] r_mem_q;
    logic [lzss_pkg::BYTE_W-1:0] r_fwd_data;
    logic                        r_fwd;
    logic                        r_busy;
    logic [AW-1:0]               r_clr_addr;

    logic                        w_we;
    logic [AW-1:0]               w_waddr;
    logic [lzss_pkg::BYTE_W-1:0] w_wdata;

    // fill sweep owns the write port until done
    always_comb begin
        w_we    = r_busy ? 1'b1 : i_we;
        w_waddr = r_busy ? r_clr_addr : i_waddr;
        w_wdata = r_busy ? '0 : i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_re) begin
            r_mem_q <= r_mem[i_raddr];
        end
    end

    // same-cycle write and read of one entry: hand over the new byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_re) begin
            r_fwd <= i_we && (i_waddr == i_raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_fwd_data <= i_wdata;
        end
    end

    assign o_rdata = r_fwd ? r_fwd_data : r_mem_q;
    assign o_busy  = r_busy;

endmodule

/* tb/sv/lzss_stream_checker.sv */
// ============================================================================
// lzss_stream_checker: byte-level predictor and scoreboard for the decompressor
// follows the length register and every compressed input transfer, expands
// tokens into the expected output bytes and compares each output transfer
// ============================================================================
module lzss_stream_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [lzss_pkg::LEN_W-1:0]  i_cfg_wr_data,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [lzss_pkg::BYTE_W-1:0] i_in_byte,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [lzss_pkg::BYTE_W-1:0] i_out_byte,
    input  logic                        i_run_last,
    input  logic                        i_stream_done,
    output int                          o_pending,
    output int                          o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST_DEPTH = 4096;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [lzss_pkg::BYTE_W-1:0] data;
        logic                        last;
        logic                        done;
    } t_out_byte;

    logic [lzss_pkg::BYTE_W-1:0] hist_mem [HIST_DEPTH];
    logic [lzss_pkg::DIST_W-1:0] wr_ptr;
    logic [lzss_pkg::LEN_W-1:0]  length_limit;
    logic [lzss_pkg::LEN_W-1:0]  produced;
    logic [lzss_pkg::FLAG_W-1:0] flag_bits;
    lzss_pkg::t_state            phase;
    logic [lzss_pkg::BYTE_W-1:0] low_byte;
    t_out_byte                   expected_bytes [$];
    int                          fails = 0;

    function automatic logic stream_over();
        return produced >= length_limit;
    endfunction

    task automatic restart_parser();
        flag_bits = lzss_pkg::FLAG_EMPTY;
        phase     = lzss_pkg::ST_FLAG;
        low_byte  = '0;
    endtask

    task automatic advance_token();
        flag_bits = flag_bits >> 1;
        phase     = (flag_bits == lzss_pkg::FLAG_EMPTY) ? lzss_pkg::ST_FLAG
                                                         : lzss_pkg::ST_TOKEN;
    endtask

    // one produced byte: into the history and onto the expected list
    task automatic emit(input logic [lzss_pkg::BYTE_W-1:0] b, output logic done);
        t_out_byte ob;
        hist_mem[wr_ptr] = b;
        wr_ptr   = wr_ptr + 1'b1;
        produced = produced + 1'b1;
        ob.data  = b;
        ob.last  = 1'b0;
        ob.done  = stream_over();
        expected_bytes.push_back(ob);
        done = ob.done;
    endtask

    task automatic expand_byte(input logic [lzss_pkg::BYTE_W-1:0] b);
        t_out_byte                   ob;
        logic [15:0]                 word;
        logic [lzss_pkg::DIST_W-1:0] src;
        int                          run;
        int                          n;
        logic                        done;
        n    = 0;
        done = 1'b0;
        if (!stream_over()) begin
            if (phase == lzss_pkg::ST_FLAG || flag_bits <= lzss_pkg::FLAG_EMPTY) begin
                flag_bits = {1'b1, b};
                phase     = lzss_pkg::ST_TOKEN;
            end else if (phase == lzss_pkg::ST_TOKEN) begin
                if (flag_bits[0]) begin
                    emit(b, done);
                    n = 1;
                    advance_token();
                end else begin
                    low_byte = b;
                    phase    = lzss_pkg::ST_HIGH;
                end
            end else begin
                word = {b, low_byte};
                src  = wr_ptr - word[15:4];
                run  = int'(word[3:0]) + 2;
                while (run > 0 && !done) begin
                    emit(hist_mem[src], done);
                    src = src + 1'b1;
                    n++;
                    run--;
                end
                advance_token();
            end
            if (done)
                restart_parser();
            if (n > 0) begin
                ob = expected_bytes.pop_back();
                ob.last = 1'b1;
                expected_bytes.push_back(ob);
            end
        end
    endtask

    task automatic check_output();
        t_out_byte ob;
        if (expected_bytes.size() == 0) begin
            fails++;
            if (fails <= REPORT_MAX)
                $display("%0t: unexpected output byte %02h last %0b done %0b",
                         $realtime, i_out_byte, i_run_last, i_stream_done);
        end else begin
            ob = expected_bytes.pop_front();
            if (ob.data !== i_out_byte || ob.last !== i_run_last
                    || ob.done !== i_stream_done) begin
                fails++;
                if (fails <= REPORT_MAX)
                    $display("%0t: compare error: expected %02h/%0b/%0b got %02h/%0b/%0b",
                             $realtime, ob.data, ob.last, ob.done,
                             i_out_byte, i_run_last, i_stream_done);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HIST_DEPTH; k++)
                hist_mem[k] = '0;
            wr_ptr       = '0;
            length_limit = '0;
            produced     = '0;
            restart_parser();
            expected_bytes.delete();
        end else begin
            // outputs first: a result never leaves in the cycle of its input
            if (i_out_valid && !i_out_stall)
                check_output();
            if (i_cfg_wr_en) begin
                length_limit = i_cfg_wr_data;
                produced     = '0;
                restart_parser();
            end
            if (i_in_valid && !i_in_stall)
                expand_byte(i_in_byte);
        end
        o_pending    <= expected_bytes.size();
        o_fail_count <= fails;
    end

endmodule

/* tb/sv/lzss_decompressor_unit_tb.sv */
// ============================================================================
// lzss_decompressor_unit_tb: stream-level test of the lzss decompressor
// drives directed and random compressed streams under several output
// lengths, with random gaps on the input and random output stalls; a
// checker beside the block predicts every output byte and counts errors
// ============================================================================
module lzss_decompressor_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET    = 270;
    localparam int SETTLE_CYCLES  = 24;     // longest copy plus read latency, with margin
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 20000;  // covers the history sweep after reset

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_cfg_wr_en;
    logic [lzss_pkg::LEN_W-1:0]  i_cfg_wr_data;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic [lzss_pkg::BYTE_W-1:0] i_in_byte;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic [lzss_pkg::BYTE_W-1:0] o_out_byte;
    logic                        o_run_last;
    logic                        o_stream_done;

    int                  pending;
    int                  fail_count;
    int                  idle_cycles = 0;

    // stimulus bookkeeping
    logic [lzss_pkg::LEN_W-1:0] cur_len = '0;
    int                  items_sent = 0;
    int                  phase_bytes = 0;
    bit                  quiet      = 1'b0;
    bit                  paused_once = 1'b0;

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    lzss_decompressor_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_byte     (i_in_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_stream_done (o_stream_done)
    );

    lzss_stream_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_byte     (i_in_byte),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_byte    (o_out_byte),
        .i_run_last    (o_run_last),
        .i_stream_done (o_stream_done),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    // watchdog: too long without any transfer or register write ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || i_cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // output stall pattern: free-running stretches, short stalls, a few long ones
    initial begin
        int  run_left;
        bit  stall_now;
        int  pick;
        run_left  = 0;
        stall_now = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (run_left == 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    stall_now = 1'b0;
                    run_left  = $urandom_range(1, 30);
                end else if (pick < 55) begin
                    // long stretch with the sink always ready
                    stall_now = 1'b0;
                    run_left  = $urandom_range(40, 120);
                end else if (pick < 93) begin
                    stall_now = 1'b1;
                    run_left  = $urandom_range(1, 3);
                end else begin
                    stall_now = 1'b1;
                    run_left  = $urandom_range(15, 50);
                end
            end
            i_out_stall <= stall_now;
            run_left--;
        end
    end

    // gap before the next input transfer, none in quiet phases
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet || pick < 60)
            return 0;
        else if (pick < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // one compressed byte, held until the block takes it
    task automatic send_byte(input logic [lzss_pkg::BYTE_W-1:0] b);
        int gap;
        gap = idle_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        phase_bytes++;
        if (cur_len != '0)
            items_sent++;
    endtask

    // drop valid and hold off until every predicted byte has come out
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    // length register write, only with the block idle
    task automatic write_length(input logic [lzss_pkg::LEN_W-1:0] len);
        wait_drained();
        // a flag or low offset byte yields nothing, so give the block time to settle
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= len;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_len = len;
    endtask

    // flag byte plus up to eight tokens; sometimes cut short to break the framing
    task automatic send_group();
        logic [7:0]                  flags;
        logic [lzss_pkg::DIST_W-1:0] back_dist;
        logic [3:0]                  nib;
        int                          pick;
        int                          stop;
        flags = 8'($urandom_range(0, 255));
        stop  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : 8;
        send_byte(flags);
        for (int k = 0; k < stop; k++) begin
            if (flags[k]) begin
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    back_dist = '0;
                else if (pick < 75)
                    // recent output, overlaps often
                    back_dist = lzss_pkg::DIST_W'($urandom_range(1, 40));
                else
                    back_dist = lzss_pkg::DIST_W'($urandom_range(0, 4095));
                nib = 4'($urandom_range(0, 15));
                // little-endian word: low byte carries the length nibble
                send_byte({back_dist[3:0], nib});
                send_byte(back_dist[11:4]);
            end
        end
    endtask

    task automatic send_noise();
        int count;
        count = $urandom_range(1, 5);
        repeat (count) send_byte(8'($urandom_range(0, 255)));
    endtask

    // one stream: new length, then groups and noise up to a byte budget
    task automatic run_phase();
        int                         pick;
        int                         budget;
        int                         grp;
        logic [lzss_pkg::LEN_W-1:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            len = '0;
        else if (pick < 16)
            len = lzss_pkg::LEN_W'($urandom_range(1, 3));
        else if (pick < 26)
            len = '1;
        else
            len = lzss_pkg::LEN_W'($urandom_range(16, 400));
        budget = (len == '0) ? 4 : (len <= 3) ? 6 : $urandom_range(25, 70);
        quiet  = ($urandom_range(0, 3) == 0);
        write_length(len);
        phase_bytes = 0;
        grp = 0;
        while (phase_bytes < budget) begin
            // sender pause until the output side has caught up
            if (grp == 1 && len > 3 && (!paused_once || $urandom_range(0, 3) == 0)) begin
                wait_drained();
                paused_once = 1'b1;
            end
            if (len == '0 || $urandom_range(0, 99) < 15)
                send_noise();
            else
                send_group();
            grp++;
        end
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid    = 1'b0;
        i_in_byte     = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero length: everything is swallowed
        write_length('0);
        send_byte(8'h5A);
        send_byte(8'hFF);
        send_byte(8'h00);

        // length 20: distance zero right after reset reads cleared history,
        // then an overlapping copy runs past the end and is cut short
        write_length(24'd20);
        send_byte(8'h06);                   // word, literal, literal, word
        send_byte(8'h00);
        send_byte(8'h00);                   // distance 0, length 2
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h1F);
        send_byte(8'h00);                   // distance 1, length 17
        // stream finished: these are dropped
        send_byte(8'h3C);
        send_byte(8'hC3);

        // maximum length: a full literal group, then the farthest longest copy
        write_length('1);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hAA);
        send_byte(8'h55);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'hFE);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hFF);                   // distance 4095, length 17

        // random streams
        while (items_sent < ITEM_TARGET)
            run_phase();

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
src/lzss_pkg.sv
src/lzss_hist.sv
src/lzss_decompressor_unit.sv
tb/sv/lzss_stream_checker.sv
tb/sv/lzss_decompressor_unit_tb.sv
